[rtl/ptm_pkg.sv]
package ptm_pkg;
    localparam int ScreenW = 320;
    localparam int ScreenH = 200;
    localparam int CordicSteps = 16;
    localparam int TexAw = 16;
    localparam int DW = 12;
    localparam int D2W = 24;
    localparam int R2W = 32;
    localparam int QW = 32;
    localparam int SW = 16;
    localparam int XW = 30;
    localparam int ZW = 20;
    localparam int signed PiQ16 = 205887;
    localparam int HalfTurnQ16 = 205888;
    localparam int AngleMax = 127;
    // |z|*128/205888 == 2|z|/3217, done as (2|z| * ceil(2^32/3217)) >> 32
    localparam int RecipM = 1335085;
    localparam int RecipShift = 32;

    localparam int DivLat = R2W;
    localparam int SqrtLat = SW;
    localparam int DepthLat = 4 + DivLat + SqrtLat;
    localparam int AngLat = 1 + CordicSteps + 3;
    localparam int PipeLat = DepthLat;

    typedef enum logic [2:0] {
        CFG_SHIFT_DIST  = 3'd0,
        CFG_SHIFT_ANGLE = 3'd1,
        CFG_LOOK_X      = 3'd2,
        CFG_LOOK_Y      = 3'd3,
        CFG_DEPTH_RATIO = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] shift_dist;
        logic [7:0] shift_angle;
        logic [8:0] look_x;
        logic [7:0] look_y;
        logic [7:0] depth_ratio;
    } t_cfg;

    function automatic logic [ZW-1:0] atan_q16(input logic [3:0] i);
        unique case (i)
            4'd0:  atan_q16 = ZW'(51472);
            4'd1:  atan_q16 = ZW'(30386);
            4'd2:  atan_q16 = ZW'(16055);
            4'd3:  atan_q16 = ZW'(8150);
            4'd4:  atan_q16 = ZW'(4091);
            4'd5:  atan_q16 = ZW'(2047);
            4'd6:  atan_q16 = ZW'(1024);
            4'd7:  atan_q16 = ZW'(512);
            4'd8:  atan_q16 = ZW'(256);
            4'd9:  atan_q16 = ZW'(128);
            4'd10: atan_q16 = ZW'(64);
            4'd11: atan_q16 = ZW'(32);
            4'd12: atan_q16 = ZW'(16);
            4'd13: atan_q16 = ZW'(8);
            4'd14: atan_q16 = ZW'(4);
            default: atan_q16 = ZW'(2);
        endcase
    endfunction
endpackage

[rtl/ptm_req_if.sv]
interface ptm_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] tex_col;
    logic [7:0] tex_row;
    logic [7:0] texel_value;
    logic [8:0] pix_x;
    logic [7:0] pix_y;
    modport source(output valid, req_type, tex_col, tex_row, texel_value, pix_x, pix_y,
                   input ready);
    modport sink(input valid, req_type, tex_col, tex_row, texel_value, pix_x, pix_y,
                 output ready);
endinterface

[rtl/ptm_pix_if.sv]
interface ptm_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_color;
    modport source(output valid, pixel_color, input ready);
    modport sink(input valid, pixel_color, output ready);
endinterface

[rtl/ptm_cfg_if.sv]
interface ptm_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [8:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

[rtl/ptm_ram.sv]
module ptm_ram #(
    parameter int Width = 8,
    parameter int Depth = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/ptm_depth.sv]
module ptm_depth
    import ptm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [DW-1:0]  i_dx,
    input  logic signed [DW-1:0]  i_dy,
    input  logic [7:0]            i_ratio,
    output logic [7:0]            o_depth
);
    // stage 0: squares; stage 1: d2 sum and r^2; then restoring divide and sqrt
    logic [D2W-1:0] r_dx2, r_dy2;
    logic [15:0]    r_r0;
    logic [D2W-1:0] r_d2;
    logic [R2W-1:0] r_r2;
    logic [D2W:0]   r_rem [DivLat+1];
    logic [QW-1:0]  r_q   [DivLat+1];
    logic [R2W-1:0] r_n   [DivLat+1];
    logic [D2W-1:0] r_dv  [DivLat+1];
    logic [QW+1:0]  r_sr  [SqrtLat+1];
    logic [SW-1:0]  r_sq  [SqrtLat+1];
    logic [QW-1:0]  r_sn  [SqrtLat+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx2 <= D2W'($unsigned(D2W'(i_dx) * D2W'(i_dx)));
            r_dy2 <= D2W'($unsigned(D2W'(i_dy) * D2W'(i_dy)));
            r_r0  <= {i_ratio, 8'd0};
            r_d2  <= r_dx2 + r_dy2;
            r_r2  <= R2W'(r_r0) * R2W'(r_r0);
            r_rem[0] <= '0;
            r_q[0]   <= '0;
            r_n[0]   <= r_r2;
            r_dv[0]  <= r_d2;
            for (int i = 0; i < DivLat; i++) begin
                logic [D2W+1:0] t;
                t = {r_rem[i], r_n[i][R2W-1-i]};
                if (r_dv[i] != '0 && t >= {2'b0, r_dv[i]}) begin
                    r_rem[i+1] <= (D2W+1)'(t - {2'b0, r_dv[i]});
                    r_q[i+1]   <= {r_q[i][QW-2:0], 1'b1};
                end else begin
                    r_rem[i+1] <= (D2W+1)'(t);
                    r_q[i+1]   <= {r_q[i][QW-2:0], 1'b0};
                end
                r_n[i+1]  <= r_n[i];
                r_dv[i+1] <= r_dv[i];
            end
            r_sr[0] <= '0;
            r_sq[0] <= '0;
            r_sn[0] <= r_q[DivLat];
            for (int j = 0; j < SqrtLat; j++) begin
                logic [QW+1:0] t2, tr;
                t2 = {r_sr[j][QW-1:0], r_sn[j][QW-1-2*j -: 2]};
                tr = {(QW+2-SW-2)'(0), r_sq[j], 2'b01};
                if (t2 >= tr) begin
                    r_sr[j+1] <= t2 - tr;
                    r_sq[j+1] <= {r_sq[j][SW-2:0], 1'b1};
                end else begin
                    r_sr[j+1] <= t2;
                    r_sq[j+1] <= {r_sq[j][SW-2:0], 1'b0};
                end
                r_sn[j+1] <= r_sn[j];
            end
        end
    end

    assign o_depth = r_sq[SqrtLat][7:0];
endmodule

[rtl/ptm_angle.sv]
module ptm_angle
    import ptm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [DW-1:0] i_dx,
    input  logic signed [DW-1:0] i_dy,
    output logic [7:0]           o_angle
);
    logic signed [XW-1:0] r_x [CordicSteps+1];
    logic signed [XW-1:0] r_y [CordicSteps+1];
    logic signed [ZW-1:0] r_z [CordicSteps+1];
    logic                 r_c [CordicSteps+1];
    logic                 r_neg;
    logic [ZW-1:0]        r_abs;
    logic                 r_zero1;
    logic [ZW+7:0]        r_prod;
    logic                 r_neg2, r_zero2;
    logic [7:0]           r_out;
    logic [7:0]           w_m;
    logic [2*ZW+1:0]      w_prod;

    assign w_prod = {r_abs, 1'b0} * (ZW+1)'(RecipM);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c[0] <= i_dx == '0 && i_dy == '0;
            if (i_dx < 0) begin
                r_x[0] <= -(XW'(i_dx) <<< 16);
                r_y[0] <= -(XW'(i_dy) <<< 16);
                r_z[0] <= i_dy >= 0 ? ZW'(PiQ16) : -ZW'(PiQ16);
            end else begin
                r_x[0] <= XW'(i_dx) <<< 16;
                r_y[0] <= XW'(i_dy) <<< 16;
                r_z[0] <= '0;
            end
            for (int i = 0; i < CordicSteps; i++) begin
                if (r_y[i] >= 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + $signed(atan_q16(4'(i)));
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - $signed(atan_q16(4'(i)));
                end
                r_c[i+1] <= r_c[i];
            end
            r_neg   <= r_z[CordicSteps] < 0;
            r_abs   <= r_z[CordicSteps] < 0 ? ZW'(-r_z[CordicSteps]) : ZW'(r_z[CordicSteps]);
            r_zero1 <= r_c[CordicSteps];
            r_prod  <= (ZW+8)'(w_prod >> RecipShift);
            r_neg2  <= r_neg;
            r_zero2 <= r_zero1;
            r_out   <= r_zero2 ? 8'd0 : (r_neg2 ? 8'(-w_m) : w_m);
        end
    end

    assign w_m = r_prod > (ZW+8)'(AngleMax) ? 8'(AngleMax) : r_prod[7:0];
    assign o_angle = r_out;
endmodule

[rtl/polar_tunnel_texture_mapper.sv]
// Pipeline: a render passes 4+32+16 depth stages, the first loaded at the transfer,
// then texel read and output. Texel loads and renders may interleave freely.
// Throughput: one item per cycle while the output register is not stalled.
// Texel writes land at the read stage, so renders see loads in transfer order.
// The pipeline advances whenever its output register is empty or taken.
// Reset: synchronous active low; registers return to shift 0/0, look 160/100, ratio 32.
module polar_tunnel_texture_mapper
    import ptm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    ptm_req_if.sink   req,
    ptm_cfg_if.sink   cfg,
    ptm_pix_if.source pix
);
    t_cfg r_cfg;
    logic w_en;
    logic signed [DW-1:0] w_dx, w_dy;
    logic [7:0] w_depth, w_angle;
    logic [PipeLat-1:0] r_vld;
    logic [PipeLat-1:0] r_wv;
    logic [TexAw-1:0] r_wa [PipeLat];
    logic [7:0] r_wd [PipeLat];
    logic r_rd_vld;
    logic [7:0] r_sd [PipeLat];
    logic [7:0] r_sa [PipeLat];
    logic [7:0] w_ang_d;
    logic [7:0] r_ang [PipeLat-AngLat];
    logic [7:0] w_rdata;
    logic r_ovld;
    logic [7:0] r_opix;
    logic [TexAw-1:0] w_addr;

    assign cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{8'd0, 8'd0, 9'd160, 8'd100, 8'd32};
        end else if (cfg.valid) begin
            case (cfg.index)
                CFG_SHIFT_DIST:  r_cfg.shift_dist  <= cfg.data[7:0];
                CFG_SHIFT_ANGLE: r_cfg.shift_angle <= cfg.data[7:0];
                CFG_LOOK_X:      r_cfg.look_x      <= cfg.data;
                CFG_LOOK_Y:      r_cfg.look_y      <= cfg.data[7:0];
                CFG_DEPTH_RATIO: r_cfg.depth_ratio <= cfg.data[7:0];
                default: ;
            endcase
        end
    end

    // advance when output slot free or being drained
    assign w_en = !r_ovld || pix.ready;
    assign req.ready = w_en;

    assign w_dx = DW'($signed({1'b0, req.pix_x})) + DW'($signed({1'b0, r_cfg.look_x}))
                  - DW'(ScreenW);
    assign w_dy = DW'($signed({1'b0, req.pix_y})) + DW'($signed({1'b0, r_cfg.look_y}))
                  - DW'(ScreenH);

    ptm_depth u_depth (.i_clk, .i_en(w_en), .i_dx(w_dx), .i_dy(w_dy),
                       .i_ratio(r_cfg.depth_ratio), .o_depth(w_depth));
    ptm_angle u_angle (.i_clk, .i_en(w_en), .i_dx(w_dx), .i_dy(w_dy), .o_angle(w_angle));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_wv     <= '0;
            r_rd_vld <= 1'b0;
            r_ovld   <= 1'b0;
        end else begin
            if (w_en) begin
                r_vld    <= {r_vld[PipeLat-2:0], req.valid && req.req_type};
                r_wv     <= {r_wv[PipeLat-2:0], req.valid && !req.req_type};
                r_rd_vld <= r_vld[PipeLat-1];
            end
            if (w_en) begin
                r_ovld <= r_rd_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd[0] <= r_cfg.shift_dist;
            r_sa[0] <= r_cfg.shift_angle;
            r_wa[0] <= {req.tex_row, req.tex_col};
            r_wd[0] <= req.texel_value;
            for (int i = 1; i < PipeLat; i++) begin
                r_sd[i] <= r_sd[i-1];
                r_sa[i] <= r_sa[i-1];
                r_wa[i] <= r_wa[i-1];
                r_wd[i] <= r_wd[i-1];
            end
            r_ang[0] <= w_angle;
            for (int k = 1; k < PipeLat-AngLat; k++) begin
                r_ang[k] <= r_ang[k-1];
            end
            r_opix <= w_rdata;
        end
    end
    assign w_ang_d = r_ang[PipeLat-AngLat-1];

    // read address held while stalled: read port re-reads same entry
    logic [TexAw-1:0] r_raddr;
    logic [TexAw-1:0] w_raddr;
    assign w_addr = {w_ang_d + r_sa[PipeLat-1], w_depth + r_sd[PipeLat-1]};
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_raddr <= w_addr;
        end
    end
    assign w_raddr = w_en ? w_addr : r_raddr;

    logic [7:0] w_ram_q;
    ptm_ram #(.Width(8), .Depth(1 << TexAw)) u_tex (
        .i_clk,
        .i_we(w_en && r_wv[PipeLat-1]),
        .i_waddr(r_wa[PipeLat-1]),
        .i_wdata(r_wd[PipeLat-1]),
        .i_raddr(w_raddr),
        .o_rdata(w_ram_q)
    );
    assign w_rdata = w_ram_q;

    assign pix.valid       = r_ovld;
    assign pix.pixel_color = r_opix;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix.valid && !pix.ready |=> pix.valid && $stable(pix.pixel_color))
        else $error("output changed under stall");
    a_no_accept_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix.valid && !pix.ready |-> !req.ready)
        else $error("accept while stalled");
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n) cfg.ready)
        else $error("cfg blocked");
endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top
    import ptm_pkg::*;
();

    localparam logic [2:0] CfgIdxUnused = 3'd7;
    localparam int IdlePct = 17;
    localparam int CycleLimit = 400000;
    localparam int DrainCycles = PipeLat + 16;

    logic i_clk;
    logic i_rst_n;

    ptm_req_if req_bus();
    ptm_cfg_if cfg_bus();
    ptm_pix_if pix_bus();

    polar_tunnel_texture_mapper u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .req     (req_bus),
        .cfg     (cfg_bus),
        .pix     (pix_bus)
    );

    t_cfg         cur_cfg;
    logic [7:0]   tex_img [0:65535];
    bit           tex_written [0:65535];
    logic [7:0]   expected_colors [$];
    int           error_count;
    int           cycle_count;
    bit           no_idle;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_bus.ready <= 1'b0;
        end else begin
            pix_bus.ready <= no_idle || ($urandom_range(99) >= IdlePct);
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // a transfer completes at the rising edge after a negedge with valid and ready
    always @(negedge i_clk) begin
        if (i_rst_n && pix_bus.valid && pix_bus.ready) begin
            if (expected_colors.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel_color %0d", pix_bus.pixel_color));
            end else begin
                if (pix_bus.pixel_color !== expected_colors[0]) begin
                    report_mismatch($sformatf("pixel_color %0d, expected %0d",
                                              pix_bus.pixel_color, expected_colors[0]));
                end
                void'(expected_colors.pop_front());
            end
        end
    end

    function automatic longint depth_of(longint dx, longint dy, logic [7:0] ratio);
        longint d2;
        longint r;
        longint q;
        longint s;
        longint t;
        d2 = dx * dx + dy * dy;
        r = longint'(ratio) * 256;
        if (d2 == 0) return 0;
        q = (r * r) / d2;
        s = 0;
        for (int b = 17; b >= 0; b--) begin
            t = s | (longint'(1) << b);
            if (t * t <= q) s = t;
        end
        return s % 256;
    endfunction

    function automatic longint angle_of(longint dx, longint dy);
        longint x;
        longint y;
        longint z;
        longint nx;
        longint ny;
        longint m;
        longint atan_tab [16];
        atan_tab = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                     256, 128, 64, 32, 16, 8, 4, 2};
        if (dx == 0 && dy == 0) return 0;
        x = dx * 65536;
        y = dy * 65536;
        z = 0;
        if (dx < 0) begin
            x = -x;
            y = -y;
            z = (dy >= 0) ? PiQ16 : -PiQ16;
        end
        for (int i = 0; i < CordicSteps; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += atan_tab[i];
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= atan_tab[i];
            end
            x = nx;
            y = ny;
        end
        m = ((z < 0 ? -z : z) * 128) / HalfTurnQ16;
        if (m > AngleMax) m = AngleMax;
        return z < 0 ? -m : m;
    endfunction

    function automatic int texel_addr(logic [8:0] px, logic [7:0] py);
        longint dx;
        longint dy;
        longint col;
        longint row;
        dx = longint'(px) + longint'(cur_cfg.look_x) - ScreenW;
        dy = longint'(py) + longint'(cur_cfg.look_y) - ScreenH;
        col = (depth_of(dx, dy, cur_cfg.depth_ratio) + cur_cfg.shift_dist) & 255;
        row = (angle_of(dx, dy) + cur_cfg.shift_angle) & 255;
        return int'(row * 256 + col);
    endfunction

    task automatic send_req(input logic rtype, input logic [7:0] col, input logic [7:0] row,
                            input logic [7:0] val, input logic [8:0] px, input logic [7:0] py);
        while (!no_idle && $urandom_range(99) < IdlePct) begin
            req_bus.valid <= 1'b0;
            req_bus.req_type <= 1'($urandom);
            @(posedge i_clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.req_type    <= rtype;
        req_bus.tex_col     <= col;
        req_bus.tex_row     <= row;
        req_bus.texel_value <= val;
        req_bus.pix_x       <= px;
        req_bus.pix_y       <= py;
        forever begin
            @(negedge i_clk);
            if (req_bus.ready) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic load_texel(input logic [7:0] col, input logic [7:0] row,
                              input logic [7:0] val);
        tex_img[{row, col}] = val;
        tex_written[{row, col}] = 1'b1;
        send_req(1'b0, col, row, val, 9'($urandom), 8'($urandom));
    endtask

    task automatic render_pixel(input logic [8:0] px, input logic [7:0] py);
        int addr;
        addr = texel_addr(px, py);
        if (!tex_written[addr]) load_texel(addr[7:0], addr[15:8], 8'($urandom));
        expected_colors.push_back(tex_img[addr]);
        send_req(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), px, py);
    endtask

    task automatic idle_req;
        req_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain_pipe;
        idle_req();
        while (expected_colors.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [8:0] data);
        case (idx)
            CFG_SHIFT_DIST:  cur_cfg.shift_dist  = data[7:0];
            CFG_SHIFT_ANGLE: cur_cfg.shift_angle = data[7:0];
            CFG_LOOK_X:      cur_cfg.look_x      = data;
            CFG_LOOK_Y:      cur_cfg.look_y      = data[7:0];
            CFG_DEPTH_RATIO: cur_cfg.depth_ratio = data[7:0];
            default: ;
        endcase
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        forever begin
            @(negedge i_clk);
            if (cfg_bus.ready) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        cfg_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_view(input logic [7:0] sd, input logic [7:0] sa, input logic [8:0] lx,
                            input logic [7:0] ly, input logic [7:0] ratio);
        drain_pipe();
        write_cfg(CFG_SHIFT_DIST, {1'b0, sd});
        write_cfg(CFG_SHIFT_ANGLE, {1'b0, sa});
        write_cfg(CFG_LOOK_X, lx);
        write_cfg(CFG_LOOK_Y, {1'b0, ly});
        write_cfg(CFG_DEPTH_RATIO, {1'b0, ratio});
    endtask

    task automatic test_reset_view;
        render_pixel(9'd160, 8'd100);
        render_pixel(9'd0, 8'd0);
        render_pixel(9'd319, 8'd199);
        render_pixel(9'd0, 8'd100);
        render_pixel(9'd0, 8'd101);
        render_pixel(9'd0, 8'd99);
        render_pixel(9'd161, 8'd100);
        render_pixel(9'd511, 8'd255);
        render_pixel(9'd160, 8'd0);
    endtask

    task automatic test_extreme_views;
        set_view(8'd255, 8'd255, 9'd0, 8'd0, 8'd0);
        render_pixel(9'd0, 8'd0);
        render_pixel(9'd319, 8'd199);
        set_view(8'd0, 8'd128, 9'd320, 8'd200, 8'd255);
        render_pixel(9'd0, 8'd0);
        render_pixel(9'd319, 8'd199);
        render_pixel(9'd1, 8'd0);
        set_view(8'd17, 8'd3, 9'd511, 8'd255, 8'd1);
        render_pixel(9'd511, 8'd255);
        render_pixel(9'd0, 8'd0);
        drain_pipe();
        write_cfg(CfgIdxUnused, 9'h1ff);
        write_cfg(CFG_SHIFT_DIST, 9'h1aa);
        render_pixel(9'd200, 8'd50);
    endtask

    task automatic random_traffic(input int n);
        logic [8:0] px;
        logic [7:0] py;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 30) begin
                load_texel(8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                if ($urandom_range(9) == 0) begin
                    px = 9'($urandom);
                    py = 8'($urandom);
                end else begin
                    px = 9'($urandom_range(319));
                    py = 8'($urandom_range(199));
                end
                render_pixel(px, py);
            end
        end
    endtask

    task automatic test_random_views;
        for (int p = 0; p < 6; p++) begin
            no_idle = (p == 3);
            set_view(8'($urandom), 8'($urandom), 9'($urandom_range(320)),
                     8'($urandom_range(200)), 8'($urandom_range(255, 1)));
            random_traffic(150);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        req_bus.valid <= 1'b0;
        req_bus.req_type <= 1'b0;
        req_bus.tex_col <= '0;
        req_bus.tex_row <= '0;
        req_bus.texel_value <= '0;
        req_bus.pix_x <= '0;
        req_bus.pix_y <= '0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= CFG_SHIFT_DIST;
        cfg_bus.data <= '0;
        cycle_count = 0;
        error_count = 0;
        no_idle = 1'b0;
        cur_cfg = '{shift_dist: 8'd0, shift_angle: 8'd0, look_x: 9'd160,
                    look_y: 8'd100, depth_ratio: 8'd32};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_view();
        test_extreme_views();
        test_random_views();
        drain_pipe();
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
